/* rtl/qau_pkg.sv */
// ----------------------------------------------------------------------------
// qau_pkg
// Opcodes and shared control types for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

  // Operation codes carried by each input word
  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_NEG    = 4'd3,
    OP_CONJ   = 4'd4,
    OP_DOT    = 4'd5,
    OP_SQMAG  = 4'd6,
    OP_SCALE  = 4'd7,
    OP_DIV    = 4'd8,
    OP_INV    = 4'd9,
    OP_DELTA  = 4'd10,
    OP_ROTATE = 4'd11,
    OP_EQUAL  = 4'd12
  } op_t;

  // Status travelling with a word from the front end through the divider
  typedef struct packed {
    logic k_neg;          // divisor k is negative (div only)
    logic is_equal;
    logic divide_by_zero;
  } flags_t;

endpackage

`default_nettype wire

/* rtl/qau_in_if.sv */
// ----------------------------------------------------------------------------
// qau_in_if
// Input channel: valid/ready handshake carrying opcode, A, B and k.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qau_in_if #(
  parameter int COMPONENT_WIDTH = 16
);
  logic                              valid;
  logic                              ready;
  logic [3:0]                        opcode;
  logic signed [COMPONENT_WIDTH-1:0] a_w;
  logic signed [COMPONENT_WIDTH-1:0] a_x;
  logic signed [COMPONENT_WIDTH-1:0] a_y;
  logic signed [COMPONENT_WIDTH-1:0] a_z;
  logic signed [COMPONENT_WIDTH-1:0] b_w;
  logic signed [COMPONENT_WIDTH-1:0] b_x;
  logic signed [COMPONENT_WIDTH-1:0] b_y;
  logic signed [COMPONENT_WIDTH-1:0] b_z;
  logic signed [COMPONENT_WIDTH-1:0] scale_factor;

  modport source (
    output valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_factor,
    input  ready
  );
  modport sink (
    input  valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_factor,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/qau_out_if.sv */
// ----------------------------------------------------------------------------
// qau_out_if
// Result channel: valid/ready handshake carrying the quaternion and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qau_out_if #(
  parameter int COMPONENT_WIDTH = 16
);
  logic                                valid;
  logic                                ready;
  logic signed [COMPONENT_WIDTH-1:0]   r_w;
  logic signed [COMPONENT_WIDTH-1:0]   r_x;
  logic signed [COMPONENT_WIDTH-1:0]   r_y;
  logic signed [COMPONENT_WIDTH-1:0]   r_z;
  logic signed [2*COMPONENT_WIDTH:0]   scalar_result;
  logic                                is_equal;
  logic                                divide_by_zero;

  modport source (
    output valid, r_w, r_x, r_y, r_z, scalar_result, is_equal, divide_by_zero,
    input  ready
  );
  modport sink (
    input  valid, r_w, r_x, r_y, r_z, scalar_result, is_equal, divide_by_zero,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/qau_front.sv */
// ----------------------------------------------------------------------------
// qau_front
// Four-stage front end: products, sums, rotation products, then rotation
// sums and selection of a signed numerator per lane and a common divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qau_front #(
  parameter int W  = 16,
  parameter int F  = 14,
  parameter int NS = 54,
  parameter int DW = 33
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [3:0]           in_op,
  input  wire logic signed [W-1:0]  in_a [4],
  input  wire logic signed [W-1:0]  in_b [4],
  input  wire logic signed [W-1:0]  in_k,
  output logic                      out_valid,
  output logic signed [NS-1:0]      out_num [4],
  output logic [DW-1:0]             out_den,
  output qau_pkg::flags_t           out_flags,
  output logic signed [2*W:0]       out_scalar
);
  import qau_pkg::*;

  localparam int PW  = 2 * W;        // single product
  localparam int SW  = 2 * W + 3;    // sum of products
  localparam int UPW = SW + W + 1;   // rotation second products
  localparam int UW  = UPW + 2;      // rotation sums
  localparam logic signed [SW-1:0] SC_MAX = SW'({1'b0, {(2*W){1'b1}}});
  localparam logic signed [SW-1:0] SC_MIN = -SC_MAX - SW'(1);

  // stage 1: products
  logic                 v_s1_r;
  op_t                  op_s1_r;
  logic signed [W-1:0]  a_s1_r [4];
  logic signed [W-1:0]  b_s1_r [4];
  logic signed [W-1:0]  k_s1_r;
  logic signed [PW-1:0] pab_s1_r [4][4];
  logic signed [PW-1:0] pab_nxt  [4][4];
  logic signed [PW-1:0] paa_s1_r [4];
  logic signed [PW-1:0] paa_nxt  [4];
  logic signed [PW-1:0] pak_s1_r [4];
  logic signed [PW-1:0] pak_nxt  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pab_nxt[i][j] = PW'(in_a[i]) * PW'(in_b[j]);
      end
      paa_nxt[i] = PW'(in_a[i]) * PW'(in_a[i]);
      pak_nxt[i] = PW'(in_a[i]) * PW'(in_k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0;
    end else if (en) begin
      v_s1_r <= in_valid;
    end
    if (en) begin
      op_s1_r  <= op_t'(in_op);
      a_s1_r   <= in_a;
      b_s1_r   <= in_b;
      k_s1_r   <= in_k;
      pab_s1_r <= pab_nxt;
      paa_s1_r <= paa_nxt;
      pak_s1_r <= pak_nxt;
    end
  end

  // stage 2: Hamilton sums, B*conj(A), dot, |A|^2 and A*v
  logic                 v_s2_r;
  op_t                  op_s2_r;
  logic signed [W-1:0]  a_s2_r [4];
  logic signed [W-1:0]  b_s2_r [4];
  logic signed [W-1:0]  k_s2_r;
  logic signed [PW-1:0] pak_s2_r [4];
  logic signed [SW-1:0] hm_s2_r [4];
  logic signed [SW-1:0] hm_nxt  [4];
  logic signed [SW-1:0] hd_s2_r [4];
  logic signed [SW-1:0] hd_nxt  [4];
  logic signed [SW-1:0] t_s2_r  [4];
  logic signed [SW-1:0] t_nxt   [4];
  logic signed [SW-1:0] dot_s2_r, dot_nxt;
  logic signed [SW-1:0] s_s2_r, s_nxt;
  logic signed [SW-1:0] p [4][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p[i][j] = SW'(pab_s1_r[i][j]);
      end
    end
    hm_nxt[0] = p[0][0] - p[1][1] - p[2][2] - p[3][3];
    hm_nxt[1] = p[0][1] + p[1][0] + p[2][3] - p[3][2];
    hm_nxt[2] = p[0][2] + p[2][0] + p[3][1] - p[1][3];
    hm_nxt[3] = p[0][3] + p[3][0] + p[1][2] - p[2][1];
    hd_nxt[0] = p[0][0] + p[1][1] + p[2][2] + p[3][3];
    hd_nxt[1] = p[0][1] - p[1][0] - p[3][2] + p[2][3];
    hd_nxt[2] = p[0][2] - p[2][0] - p[1][3] + p[3][1];
    hd_nxt[3] = p[0][3] - p[3][0] - p[2][1] + p[1][2];
    // vector part only: the scalar of v is zero
    t_nxt[0]  = -p[1][1] - p[2][2] - p[3][3];
    t_nxt[1]  = p[0][1] + p[2][3] - p[3][2];
    t_nxt[2]  = p[0][2] + p[3][1] - p[1][3];
    t_nxt[3]  = p[0][3] + p[1][2] - p[2][1];
    dot_nxt   = hd_nxt[0];
    s_nxt     = SW'(paa_s1_r[0]) + SW'(paa_s1_r[1]) + SW'(paa_s1_r[2]) + SW'(paa_s1_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s2_r <= 1'b0;
    end else if (en) begin
      v_s2_r <= v_s1_r;
    end
    if (en) begin
      op_s2_r  <= op_s1_r;
      a_s2_r   <= a_s1_r;
      b_s2_r   <= b_s1_r;
      k_s2_r   <= k_s1_r;
      pak_s2_r <= pak_s1_r;
      hm_s2_r  <= hm_nxt;
      hd_s2_r  <= hd_nxt;
      t_s2_r   <= t_nxt;
      dot_s2_r <= dot_nxt;
      s_s2_r   <= s_nxt;
    end
  end

  // stage 3: (A*v)*conj(A) products, scalar result, zero-norm test
  logic                  v_s3_r;
  op_t                   op_s3_r;
  logic signed [W-1:0]   a_s3_r [4];
  logic signed [W-1:0]   b_s3_r [4];
  logic signed [W-1:0]   k_s3_r;
  logic signed [PW-1:0]  pak_s3_r [4];
  logic signed [SW-1:0]  hm_s3_r [4];
  logic signed [SW-1:0]  hd_s3_r [4];
  logic signed [SW-1:0]  s_s3_r;
  logic                  sz_s3_r;
  logic signed [UPW-1:0] up_s3_r [4][4];
  logic signed [UPW-1:0] up_nxt  [4][4];
  logic signed [2*W:0]   sc_s3_r, sc_nxt;
  logic signed [W:0]     ca [4];
  logic signed [SW-1:0]  sc_src;

  always_comb begin
    ca[0] = (W+1)'(a_s2_r[0]);
    for (int j = 1; j < 4; j++) begin
      ca[j] = -((W+1)'(a_s2_r[j]));
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        up_nxt[i][j] = UPW'(t_s2_r[i]) * UPW'(ca[j]);
      end
    end
    // saturate the exact sum into the scalar port
    sc_src = (op_s2_r == OP_DOT) ? dot_s2_r : s_s2_r;
    if (sc_src > SC_MAX) begin
      sc_nxt = (2*W+1)'(SC_MAX);
    end else if (sc_src < SC_MIN) begin
      sc_nxt = (2*W+1)'(SC_MIN);
    end else begin
      sc_nxt = (2*W+1)'(sc_src);
    end
    if (op_s2_r != OP_DOT && op_s2_r != OP_SQMAG) begin
      sc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s3_r <= 1'b0;
    end else if (en) begin
      v_s3_r <= v_s2_r;
    end
    if (en) begin
      op_s3_r  <= op_s2_r;
      a_s3_r   <= a_s2_r;
      b_s3_r   <= b_s2_r;
      k_s3_r   <= k_s2_r;
      pak_s3_r <= pak_s2_r;
      hm_s3_r  <= hm_s2_r;
      hd_s3_r  <= hd_s2_r;
      s_s3_r   <= s_s2_r;
      sz_s3_r  <= (s_s2_r == '0);
      up_s3_r  <= up_nxt;
      sc_s3_r  <= sc_nxt;
    end
  end

  // stage 4: rotation sums and operand selection
  logic signed [UW-1:0] u [4];
  logic signed [NS-1:0] num_nxt [4];
  logic [DW-1:0]        den_nxt;
  flags_t               fl_nxt;
  logic signed [W:0]    kx, kabs;

  always_comb begin
    u[0] = '0;
    u[1] = UW'(up_s3_r[0][1]) + UW'(up_s3_r[1][0]) + UW'(up_s3_r[2][3]) - UW'(up_s3_r[3][2]);
    u[2] = UW'(up_s3_r[0][2]) + UW'(up_s3_r[2][0]) + UW'(up_s3_r[3][1]) - UW'(up_s3_r[1][3]);
    u[3] = UW'(up_s3_r[0][3]) + UW'(up_s3_r[3][0]) + UW'(up_s3_r[1][2]) - UW'(up_s3_r[2][1]);
    kx   = (W+1)'(k_s3_r);
    kabs = kx[W] ? -kx : kx;
    for (int i = 0; i < 4; i++) begin
      num_nxt[i] = '0;
    end
    den_nxt = DW'(1);
    fl_nxt  = '0;
    case (op_s3_r)
      OP_ADD: begin
        for (int i = 0; i < 4; i++) num_nxt[i] = NS'(a_s3_r[i]) + NS'(b_s3_r[i]);
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) num_nxt[i] = NS'(a_s3_r[i]) - NS'(b_s3_r[i]);
      end
      OP_MUL: begin
        for (int i = 0; i < 4; i++) num_nxt[i] = NS'(hm_s3_r[i]);
        den_nxt = DW'(1) << F;
      end
      OP_NEG: begin
        for (int i = 0; i < 4; i++) num_nxt[i] = -NS'(a_s3_r[i]);
      end
      OP_CONJ: begin
        num_nxt[0] = NS'(a_s3_r[0]);
        for (int i = 1; i < 4; i++) num_nxt[i] = -NS'(a_s3_r[i]);
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) num_nxt[i] = NS'(pak_s3_r[i]);
        den_nxt = DW'(1) << F;
      end
      OP_DIV: begin
        if (k_s3_r == '0) begin
          fl_nxt.divide_by_zero = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) num_nxt[i] = NS'(a_s3_r[i]) <<< F;
          den_nxt      = DW'(kabs);
          fl_nxt.k_neg = k_s3_r[W-1];
        end
      end
      OP_INV, OP_DELTA, OP_ROTATE: begin
        if (sz_s3_r) begin
          fl_nxt.divide_by_zero = 1'b1;
        end else begin
          den_nxt = DW'(s_s3_r);
          for (int i = 0; i < 4; i++) begin
            if (op_s3_r == OP_INV) begin
              num_nxt[i] = (i == 0) ? (NS'(a_s3_r[i]) <<< (2*F))
                                    : -(NS'(a_s3_r[i]) <<< (2*F));
            end else if (op_s3_r == OP_DELTA) begin
              num_nxt[i] = NS'(hd_s3_r[i]) <<< F;
            end else begin
              num_nxt[i] = NS'(u[i]);
            end
          end
        end
      end
      OP_EQUAL: begin
        fl_nxt.is_equal = (a_s3_r[0] == b_s3_r[0]) && (a_s3_r[1] == b_s3_r[1]) &&
                          (a_s3_r[2] == b_s3_r[2]) && (a_s3_r[3] == b_s3_r[3]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_s3_r;
    end
    if (en) begin
      out_num    <= num_nxt;
      out_den    <= den_nxt;
      out_flags  <= fl_nxt;
      out_scalar <= sc_s3_r;
    end
  end

endmodule

`default_nettype wire

/* rtl/qau_div_stage.sv */
// ----------------------------------------------------------------------------
// qau_div_stage
// One restoring-division step for four lanes sharing a divisor: settles
// quotient bit BIT and passes remainder, divisor and side data on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qau_div_stage #(
  parameter int W   = 16,
  parameter int DW  = 33,
  parameter int RW  = 55,
  parameter int SBW = 48,
  parameter int BIT = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [DW-1:0]  in_den,
  input  wire logic [RW-1:0]  in_rem [4],
  input  wire logic [W-1:0]   in_q [4],
  input  wire logic [SBW-1:0] in_sb,
  output logic                out_valid,
  output logic [DW-1:0]       out_den,
  output logic [RW-1:0]       out_rem [4],
  output logic [W-1:0]        out_q [4],
  output logic [SBW-1:0]      out_sb
);

  logic [RW-1:0] dsh;
  logic [RW-1:0] rem_nxt [4];
  logic [W-1:0]  q_nxt [4];

  // trial subtract of the divisor at this bit weight
  always_comb begin
    dsh = RW'(in_den) << BIT;
    for (int l = 0; l < 4; l++) begin
      q_nxt[l] = in_q[l];
      if (in_rem[l] >= dsh) begin
        rem_nxt[l]    = in_rem[l] - dsh;
        q_nxt[l][BIT] = 1'b1;
      end else begin
        rem_nxt[l]    = in_rem[l];
        q_nxt[l][BIT] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_den <= in_den;
      out_rem <= rem_nxt;
      out_q   <= q_nxt;
      out_sb  <= in_sb;
    end
  end

endmodule

`default_nettype wire

/* rtl/qau_divider.sv */
// ----------------------------------------------------------------------------
// qau_divider
// Pipelined rounding divider for four lanes: magnitude and half-divisor
// bias, range check, one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qau_divider #(
  parameter int W  = 16,
  parameter int NS = 54,
  parameter int DW = 33,
  parameter int RW = 55
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [NS-1:0] in_num [4],
  input  wire logic [DW-1:0]        in_den,
  input  wire qau_pkg::flags_t      in_flags,
  input  wire logic signed [2*W:0]  in_scalar,
  output logic                      out_valid,
  output logic signed [W-1:0]       out_r [4],
  output qau_pkg::flags_t           out_flags,
  output logic signed [2*W:0]       out_scalar
);
  import qau_pkg::*;

  localparam int FLW = $bits(flags_t);
  localparam int SBW = (2*W+1) + FLW + 8;   // scalar, flags, sign x4, range x4
  localparam logic [W-1:0] Q_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] Q_NEG = {1'b1, {(W-1){1'b0}}};

  // bias stage: |n| + floor(d/2), sign of the quotient
  logic                 v_p_r;
  logic [DW-1:0]        den_p_r;
  logic [RW-1:0]        rem_p_r [4];
  logic [3:0]           neg_p_r;
  flags_t               fl_p_r;
  logic signed [2*W:0]  sc_p_r;
  logic [NS-1:0]        mag [4];
  logic [RW-1:0]        rem_nxt [4];
  logic [3:0]           neg_nxt;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag[l]     = in_num[l][NS-1] ? NS'(-in_num[l]) : NS'(in_num[l]);
      rem_nxt[l] = RW'(mag[l]) + RW'(in_den >> 1);
      neg_nxt[l] = in_num[l][NS-1] ^ in_flags.k_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p_r <= 1'b0;
    end else if (en) begin
      v_p_r <= in_valid;
    end
    if (en) begin
      den_p_r <= in_den;
      rem_p_r <= rem_nxt;
      neg_p_r <= neg_nxt;
      fl_p_r  <= in_flags;
      sc_p_r  <= in_scalar;
    end
  end

  // range stage: a quotient of 2^W or more saturates regardless
  logic               v_c [W+1];
  logic [DW-1:0]      den_c [W+1];
  logic [RW-1:0]      rem_c [W+1][4];
  logic [W-1:0]       q_c [W+1][4];
  logic [SBW-1:0]     sb_c [W+1];
  logic [3:0]         ovf_nxt;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      ovf_nxt[l] = (rem_p_r[l] >> W) >= RW'(den_p_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c[0] <= 1'b0;
    end else if (en) begin
      v_c[0] <= v_p_r;
    end
    if (en) begin
      den_c[0] <= den_p_r;
      rem_c[0] <= rem_p_r;
      for (int l = 0; l < 4; l++) q_c[0][l] <= '0;
      sb_c[0]  <= {sc_p_r, fl_p_r, neg_p_r, ovf_nxt};
    end
  end

  // quotient bits, most significant first
  for (genvar g = 0; g < W; g++) begin : g_step
    qau_div_stage #(
      .W(W), .DW(DW), .RW(RW), .SBW(SBW), .BIT(W-1-g)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v_c[g]),
      .in_den   (den_c[g]),
      .in_rem   (rem_c[g]),
      .in_q     (q_c[g]),
      .in_sb    (sb_c[g]),
      .out_valid(v_c[g+1]),
      .out_den  (den_c[g+1]),
      .out_rem  (rem_c[g+1]),
      .out_q    (q_c[g+1]),
      .out_sb   (sb_c[g+1])
    );
  end

  // sign and saturation into the output register
  logic [SBW-1:0]      sb_last;
  logic [3:0]          ovf_l, neg_l;
  logic [W-1:0]        q_l;
  logic signed [W-1:0] r_nxt [4];

  always_comb begin
    sb_last = sb_c[W];
    ovf_l   = sb_last[3:0];
    neg_l   = sb_last[7:4];
    for (int l = 0; l < 4; l++) begin
      q_l = q_c[W][l];
      if (!neg_l[l]) begin
        r_nxt[l] = (ovf_l[l] || q_l > Q_POS) ? signed'(Q_POS) : signed'(q_l);
      end else begin
        r_nxt[l] = (ovf_l[l] || q_l > Q_NEG) ? signed'(Q_NEG) : signed'(W'(-q_l));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_c[W];
    end
    if (en) begin
      out_r      <= r_nxt;
      out_flags  <= sb_last[8 +: FLW];
      out_scalar <= sb_last[SBW-1 -: (2*W+1)];
    end
  end

endmodule

`default_nettype wire

/* rtl/quaternion_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Pipelined fixed-point quaternion ALU: add, sub, product, neg, conj, dot,
// squared magnitude, scale, divide, inverse, delta, rotate and equality.
// Pipeline: four front-end stages, bias and range stages, one divider
// stage per quotient bit, then the output register.
// Throughput: one word per cycle; the whole pipe holds while the output
// word waits, so ready follows the result side.
// Reset: synchronous active-low rst_n clears every stage valid bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  qau_in_if.sink      in_ch,
  qau_out_if.source   out_ch
);
  import qau_pkg::*;

  localparam int W   = COMPONENT_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int SW  = 2 * W + 3;
  localparam int UW  = SW + W + 3;
  localparam int N1  = (UW > SW + F) ? UW : SW + F;
  localparam int NS  = (N1 > W + 1 + 2*F) ? N1 : W + 1 + 2*F;
  localparam int DW  = (2*W + 1 > F + 1) ? 2*W + 1 : F + 1;
  localparam int RW  = (NS + 1 > DW + W) ? NS + 1 : DW + W;

  logic                 en;
  logic signed [W-1:0]  a [4];
  logic signed [W-1:0]  b [4];
  logic                 f_valid;
  logic signed [NS-1:0] f_num [4];
  logic [DW-1:0]        f_den;
  flags_t               f_flags;
  logic signed [2*W:0]  f_scalar;
  logic                 d_valid;
  logic signed [W-1:0]  d_r [4];
  flags_t               d_flags;
  logic signed [2*W:0]  d_scalar;

  // pipe advances unless a finished word is held at the output
  assign en          = !d_valid || out_ch.ready;
  assign in_ch.ready = en;

  assign a = '{in_ch.a_w, in_ch.a_x, in_ch.a_y, in_ch.a_z};
  assign b = '{in_ch.b_w, in_ch.b_x, in_ch.b_y, in_ch.b_z};

  qau_front #(.W(W), .F(F), .NS(NS), .DW(DW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.opcode),
    .in_a      (a),
    .in_b      (b),
    .in_k      (in_ch.scale_factor),
    .out_valid (f_valid),
    .out_num   (f_num),
    .out_den   (f_den),
    .out_flags (f_flags),
    .out_scalar(f_scalar)
  );

  qau_divider #(.W(W), .NS(NS), .DW(DW), .RW(RW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_num    (f_num),
    .in_den    (f_den),
    .in_flags  (f_flags),
    .in_scalar (f_scalar),
    .out_valid (d_valid),
    .out_r     (d_r),
    .out_flags (d_flags),
    .out_scalar(d_scalar)
  );

  // result word
  assign out_ch.valid          = d_valid;
  assign out_ch.r_w            = d_r[0];
  assign out_ch.r_x            = d_r[1];
  assign out_ch.r_y            = d_r[2];
  assign out_ch.r_z            = d_r[3];
  assign out_ch.scalar_result  = d_scalar;
  assign out_ch.is_equal       = d_flags.is_equal;
  assign out_ch.divide_by_zero = d_flags.divide_by_zero;

  // a zero divisor leaves every quaternion component and the scalar at zero
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid && d_flags.divide_by_zero |->
      d_r[0] == '0 && d_r[1] == '0 && d_r[2] == '0 && d_r[3] == '0 && d_scalar == '0)
    else $error("divide_by_zero word with non-zero result");

  // equality and zero divisor come from different opcodes
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid |-> !(d_flags.is_equal && d_flags.divide_by_zero))
    else $error("is_equal and divide_by_zero both set");

  // an equality word carries no arithmetic result
  a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid && d_flags.is_equal |->
      d_scalar == '0 && d_r[0] == '0 && d_r[3] == '0)
    else $error("equality word with arithmetic data");

  // a stalled output word is kept in place by the pipe enable
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid && !out_ch.ready |=> d_valid && $stable(d_r[1]) && $stable(d_scalar))
    else $error("output word changed during stall");

endmodule

`default_nettype wire
